FILE: sv/assert_macros.svh
// assertion macros shared by the escape-time iterator modules
// expects clk and rst_n to be visible in the module that expands them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ETF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication outside reset
`define ETF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication outside reset
`define ETF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/etf_pkg.sv
// shared types, constants and helpers for the escape-time fractal iterator
// no dependencies; imported by every module of the block
package etf_pkg;

    // word widths
    localparam int DATA_W  = 32;
    localparam int STEP_W  = 31;
    localparam int LIMIT_W = 16;
    localparam int COUNT_W = 8;
    localparam int ADDR_W  = 3;
    localparam int PROD_W  = 64;
    localparam int ESC_W   = PROD_W + 1;
    localparam int SAT_W   = PROD_W + 2;

    // register reset values
    localparam logic                RST_JULIA_MODE = 1'b0;
    localparam logic signed [31:0]  RST_ORIGIN_RE  = -32'sd536870912;
    localparam logic signed [31:0]  RST_ORIGIN_IM  = -32'sd536870912;
    localparam logic [STEP_W-1:0]   RST_STEP_SIZE  = 31'd268435;
    localparam logic [LIMIT_W-1:0]  RST_ITER_LIMIT = 16'd255;
    localparam logic signed [31:0]  RST_CONST_RE   = 32'sd0;
    localparam logic signed [31:0]  RST_CONST_IM   = 32'sd0;

    // saturation bounds of a signed 32-bit word
    localparam logic signed [SAT_W-1:0] S32_MAX = (SAT_W'(1) <<< 31) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] S32_MIN = -(SAT_W'(1) <<< 31);

    // configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_JULIA_MODE = 3'd0,
        REG_ORIGIN_RE  = 3'd1,
        REG_ORIGIN_IM  = 3'd2,
        REG_STEP_SIZE  = 3'd3,
        REG_ITER_LIMIT = 3'd4,
        REG_CONST_RE   = 3'd5,
        REG_CONST_IM   = 3'd6
    } reg_idx_t;

    // configuration register file contents
    typedef struct packed {
        logic                julia_mode;
        logic signed [31:0]  origin_re;
        logic signed [31:0]  origin_im;
        logic [STEP_W-1:0]   step_size;
        logic [LIMIT_W-1:0]  iteration_limit;
        logic signed [31:0]  const_re;
        logic signed [31:0]  const_im;
    } cfg_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_POINT,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_idx;
        logic scale;
        logic point;
        logic mul;
        logic update;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic limit_hit;
        logic escape;
    } ctrl_sts_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX)
        begin
            r = S32_MAX[DATA_W-1:0];
        end
        else if (v < S32_MIN)
        begin
            r = S32_MIN[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/etf_in_if.sv
// pixel request channel: valid/ready with row and column index
// depends on nothing; used by the top level of the iterator
interface etf_in_if #(
    parameter int INDEX_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;

    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

FILE: sv/etf_out_if.sv
// result channel: valid/ready with the escape count of one pixel
// depends on etf_pkg for the count width
interface etf_out_if
    import etf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] iter_count;

    modport source (output valid, output iter_count, input ready);
    modport sink   (input valid, input iter_count, output ready);
endinterface

FILE: sv/escape_time_fractal_iterator_top.sv
// Escape-time fractal iterator (Mandelbrot or Julia set), signed fixed point with FRAC_BITS
// fraction bits. Each pixel beat carries a row and column; the block forms the point
// origin + index*step_size and iterates z = z*z + c until |z|^2 reaches 4 or the configured
// iteration limit is met, then returns the step count modulo 256. The step count is the
// number of iterations run, at most iteration_limit. Each iteration first registers the
// three 32x32 products, then runs the escape test and the z update. One pixel is in
// flight at a time; the next is accepted as soon as the previous result sits in the
// output register. Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
// while the block is idle; the user must keep to this, as the block leaves it unchecked.
// Depends on etf_pkg, etf_in_if, etf_out_if, etf_cfg_regs, etf_ctrl and etf_datapath.
module escape_time_fractal_iterator_top
    import etf_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int INDEX_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    etf_in_if.sink            pixel,
    etf_out_if.source         result,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0] cfg_wdata
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    logic [INDEX_BITS-1:0] pix_row;
    logic [INDEX_BITS-1:0] pix_col;

    assign pix_row = pixel.row[INDEX_BITS-1:0];
    assign pix_col = pixel.col[INDEX_BITS-1:0];

    // configuration registers
    etf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencing and handshakes
    etf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic
    etf_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .row        (pix_row),
        .col        (pix_col),
        .sts        (sts),
        .iter_count (result.iter_count)
    );

endmodule

FILE: sv/etf_cfg_regs.sv
// configuration register bank of the iterator, written through a plain write port
// depends on etf_pkg for the register layout and reset values
module etf_cfg_regs
    import etf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0] cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_JULIA_MODE: cfg_next.julia_mode      = cfg_wdata[0];
                REG_ORIGIN_RE:  cfg_next.origin_re       = signed'(cfg_wdata);
                REG_ORIGIN_IM:  cfg_next.origin_im       = signed'(cfg_wdata);
                REG_STEP_SIZE:  cfg_next.step_size       = cfg_wdata[STEP_W-1:0];
                REG_ITER_LIMIT: cfg_next.iteration_limit = cfg_wdata[LIMIT_W-1:0];
                REG_CONST_RE:   cfg_next.const_re        = signed'(cfg_wdata);
                REG_CONST_IM:   cfg_next.const_im        = signed'(cfg_wdata);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.julia_mode      <= RST_JULIA_MODE;
            cfg_reg.origin_re       <= RST_ORIGIN_RE;
            cfg_reg.origin_im       <= RST_ORIGIN_IM;
            cfg_reg.step_size       <= RST_STEP_SIZE;
            cfg_reg.iteration_limit <= RST_ITER_LIMIT;
            cfg_reg.const_re        <= RST_CONST_RE;
            cfg_reg.const_im        <= RST_CONST_IM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/etf_datapath.sv
// datapath of the iterator: pixel point, z registers, squaring multipliers, escape test
// depends on etf_pkg and assert_macros.svh; driven by etf_ctrl commands
`include "assert_macros.svh"

module etf_datapath
    import etf_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int INDEX_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  ctrl_cmd_t             cmd,
    input  logic [INDEX_BITS-1:0] row,
    input  logic [INDEX_BITS-1:0] col,
    output ctrl_sts_t             sts,
    output logic [COUNT_W-1:0]    iter_count
);

    localparam int SPROD_W = INDEX_BITS + STEP_W;
    localparam logic [ESC_W-1:0] ESC_BOUND = ESC_W'(4) << FRAC_BITS;

    logic [INDEX_BITS-1:0]      row_reg;
    logic [INDEX_BITS-1:0]      col_reg;
    logic [SPROD_W-1:0]         prod_re_reg;
    logic [SPROD_W-1:0]         prod_im_reg;
    logic signed [DATA_W-1:0]   zre_reg;
    logic signed [DATA_W-1:0]   zim_reg;
    logic signed [DATA_W-1:0]   cre_reg;
    logic signed [DATA_W-1:0]   cim_reg;
    logic signed [PROD_W-1:0]   sq_re_reg;
    logic signed [PROD_W-1:0]   sq_im_reg;
    logic signed [PROD_W-1:0]   xp_reg;
    logic [LIMIT_W-1:0]         steps_reg;
    logic [COUNT_W-1:0]         iter_count_reg;

    logic signed [SAT_W-1:0]    pt_re_sum;
    logic signed [SAT_W-1:0]    pt_im_sum;
    logic signed [DATA_W-1:0]   pt_re;
    logic signed [DATA_W-1:0]   pt_im;
    logic signed [DATA_W-1:0]   zre_init;
    logic signed [DATA_W-1:0]   zim_init;
    logic signed [DATA_W-1:0]   cre_init;
    logic signed [DATA_W-1:0]   cim_init;
    logic signed [PROD_W-1:0]   sre;
    logic signed [PROD_W-1:0]   sim;
    logic signed [PROD_W-1:0]   cross_term;
    logic [ESC_W-1:0]           mag_sum;
    logic signed [SAT_W-1:0]    re_sum;
    logic signed [SAT_W-1:0]    im_sum;
    logic signed [DATA_W-1:0]   zre_next;
    logic signed [DATA_W-1:0]   zim_next;

    // pixel point: origin plus scaled index, clamped to a word
    assign pt_re_sum = SAT_W'(signed'(cfg.origin_re)) + SAT_W'(signed'({1'b0, prod_re_reg}));
    assign pt_im_sum = SAT_W'(signed'(cfg.origin_im)) + SAT_W'(signed'({1'b0, prod_im_reg}));
    assign pt_re     = sat32(pt_re_sum);
    assign pt_im     = sat32(pt_im_sum);

    // starting z and c for the selected set
    assign zre_init = cfg.julia_mode ? pt_re : '0;
    assign zim_init = cfg.julia_mode ? pt_im : '0;
    assign cre_init = cfg.julia_mode ? signed'(cfg.const_re) : pt_re;
    assign cim_init = cfg.julia_mode ? signed'(cfg.const_im) : pt_im;

    // rescale the registered products (arithmetic shift floors)
    assign sre        = sq_re_reg >>> FRAC_BITS;
    assign sim        = sq_im_reg >>> FRAC_BITS;
    assign cross_term = xp_reg >>> (FRAC_BITS - 1);

    // escape test on |z|^2, both squares are non-negative
    assign mag_sum = ESC_W'(unsigned'(sre)) + ESC_W'(unsigned'(sim));

    // next z from the old z
    assign re_sum   = SAT_W'(sre) - SAT_W'(sim) + SAT_W'(cre_reg);
    assign im_sum   = SAT_W'(cross_term) + SAT_W'(cim_reg);
    assign zre_next = sat32(re_sum);
    assign zim_next = sat32(im_sum);

    // status back to the controller
    assign sts.limit_hit = (steps_reg == cfg.iteration_limit);
    assign sts.escape    = (mag_sum >= ESC_BOUND);

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_idx)
        begin
            row_reg <= row;
            col_reg <= col;
        end
        if (cmd.scale)
        begin
            prod_re_reg <= SPROD_W'(col_reg) * SPROD_W'(cfg.step_size);
            prod_im_reg <= SPROD_W'(row_reg) * SPROD_W'(cfg.step_size);
        end
        if (cmd.point)
        begin
            zre_reg   <= zre_init;
            zim_reg   <= zim_init;
            cre_reg   <= cre_init;
            cim_reg   <= cim_init;
            steps_reg <= '0;
        end
        else if (cmd.update)
        begin
            zre_reg   <= zre_next;
            zim_reg   <= zim_next;
            steps_reg <= steps_reg + LIMIT_W'(1);
        end
        if (cmd.mul)
        begin
            sq_re_reg <= PROD_W'(zre_reg) * PROD_W'(zre_reg);
            sq_im_reg <= PROD_W'(zim_reg) * PROD_W'(zim_reg);
            xp_reg    <= PROD_W'(zre_reg) * PROD_W'(zim_reg);
        end
        if (cmd.out_load)
        begin
            iter_count_reg <= steps_reg[COUNT_W-1:0];
        end
    end

    assign iter_count = iter_count_reg;

    // the step counter advances by exactly one per update
    `ETF_ASSERT_NXT(a_step_incr, cmd.update && !cmd.point,
        steps_reg == $past(steps_reg) + LIMIT_W'(1), "step counter did not advance by one")

endmodule

FILE: sv/etf_ctrl.sv
// controller state machine of the iterator: handshakes, sequencing, result register valid
// depends on etf_pkg and assert_macros.svh; commands etf_datapath
`include "assert_macros.svh"

module etf_ctrl
    import etf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // result register can take a new beat
    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_idx = 1'b1;
                    state_next   = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_POINT;
            end
            ST_POINT:
            begin
                cmd.point  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (sts.limit_hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (sts.escape)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state and valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // escape test only reads products computed in the cycle before
    `ETF_ASSERT_IMP(a_step_after_mul, state_reg == ST_STEP,
        $past(state_reg) == ST_MUL, "escape test without fresh products")
    // no multiply once the step limit is reached
    `ETF_ASSERT_IMP(a_mul_below_limit, cmd.mul, !sts.limit_hit,
        "iteration started at the step limit")
    // a result never overwrites one that is still waiting
    `ETF_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready,
        "result register overwritten")

endmodule

FILE: bench/testbench.sv
// self-checking bench for the escape-time fractal iterator: directed corners, then random views
// depends on etf_pkg, etf_in_if, etf_out_if and escape_time_fractal_iterator_top
module testbench;
    import etf_pkg::*;

    localparam int FRAC_BITS        = 28;
    localparam int INDEX_BITS       = 12;
    localparam int CYCLE_LIMIT      = 4000000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 600;
    localparam int LONG_HOLD_AT     = 40;
    localparam int LONG_HOLD_CYCLES = 2000;
    localparam int PHASE_ITEMS      = 100;
    localparam int MAX_REPORTS      = 10;

    localparam longint WORD_MAX     = 64'sd2147483647;
    localparam longint WORD_MIN     = -64'sd2147483648;
    localparam longint ESCAPE_BOUND = longint'(4) <<< FRAC_BITS;

    // index with no register behind it
    localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd7;

    // kinds of random view
    typedef enum int {
        VIEW_MANDEL,
        VIEW_JULIA,
        VIEW_WILD,
        VIEW_WRAP
    } view_t;

    typedef struct {
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        logic                  hold;
    } pixel_req_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [ADDR_W-1:0]     cfg_addr  = '0;
    logic [DATA_W-1:0]     cfg_wdata = '0;
    logic                  px_valid  = 1'b0;
    logic [INDEX_BITS-1:0] px_row    = '0;
    logic [INDEX_BITS-1:0] px_col    = '0;
    logic                  res_ready = 1'b0;

    cfg_t                 live_cfg;
    pixel_req_t           pixel_q[$];
    logic [COUNT_W-1:0]   escape_counts_q[$];
    int                   accepted_cnt = 0;
    int                   received_cnt = 0;
    int                   fail_cnt     = 0;
    int                   cycle_cnt    = 0;
    int                   gap_left     = 0;
    int                   stall_left   = 0;
    int                   long_left    = 0;
    logic                 long_done    = 1'b0;
    logic                 calm         = 1'b0;

    etf_in_if #(.INDEX_BITS(INDEX_BITS)) pixel_ch ();
    etf_out_if result_ch ();

    assign pixel_ch.valid   = px_valid;
    assign pixel_ch.row     = px_row;
    assign pixel_ch.col     = px_col;
    assign result_ch.ready  = res_ready;

    escape_time_fractal_iterator_top #(
        .FRAC_BITS (FRAC_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // clamp to the signed 32-bit range
    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX)
        begin
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // iteration count of one pixel under the current register settings
    function automatic logic [COUNT_W-1:0] escape_steps(input logic [INDEX_BITS-1:0] row,
                                                        input logic [INDEX_BITS-1:0] col);
        longint      pre;
        longint      pim;
        longint      zre;
        longint      zim;
        longint      cre;
        longint      cim;
        longint      sq_re;
        longint      sq_im;
        longint      cross_term;
        int unsigned n;
        pre = clamp_word(longint'($signed(live_cfg.origin_re))
                         + longint'(col) * longint'(live_cfg.step_size));
        pim = clamp_word(longint'($signed(live_cfg.origin_im))
                         + longint'(row) * longint'(live_cfg.step_size));
        if (live_cfg.julia_mode)
        begin
            zre = pre;
            zim = pim;
            cre = longint'($signed(live_cfg.const_re));
            cim = longint'($signed(live_cfg.const_im));
        end
        else
        begin
            zre = 0;
            zim = 0;
            cre = pre;
            cim = pim;
        end
        n = 0;
        while (n < live_cfg.iteration_limit)
        begin
            sq_re = (zre * zre) >>> FRAC_BITS;
            sq_im = (zim * zim) >>> FRAC_BITS;
            if (sq_re + sq_im >= ESCAPE_BOUND)
            begin
                break;
            end
            // doubled cross term, floored
            cross_term = (zre * zim) >>> (FRAC_BITS - 1);
            zre = clamp_word(sq_re - sq_im + cre);
            zim = clamp_word(cross_term + cim);
            n++;
        end
        return n[COUNT_W-1:0];
    endfunction

    // random index, corners now and then
    function automatic logic [INDEX_BITS-1:0] pick_index();
        if ($urandom_range(0, 9) == 0)
        begin
            return {INDEX_BITS{$urandom_range(0, 1) == 1}};
        end
        return INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1));
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        logic       took;
        pixel_req_t nxt;
        if (!rst_n)
        begin
            px_valid     <= 1'b0;
            px_row       <= '0;
            px_col       <= '0;
            gap_left     <= 0;
            accepted_cnt <= 0;
        end
        else
        begin
            took = px_valid && pixel_ch.ready;
            if (took)
            begin
                escape_counts_q.push_back(escape_steps(px_row, px_col));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (px_valid && !took)
            begin
                // beat still on offer
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                px_valid <= 1'b0;
            end
            else if (pixel_q.size() != 0
                     && !(pixel_q[0].hold && (accepted_cnt + int'(took) != received_cnt)))
            begin
                nxt = pixel_q.pop_front();
                px_valid <= 1'b1;
                px_row   <= nxt.row;
                px_col   <= nxt.col;
                if (!calm && $urandom_range(0, 5) == 0)
                begin
                    gap_left <= $urandom_range(1, 15);
                end
            end
            else
            begin
                px_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        logic [COUNT_W-1:0] want;
        if (!rst_n)
        begin
            res_ready    <= 1'b0;
            stall_left   <= 0;
            long_left    <= 0;
            long_done    <= 1'b0;
            received_cnt <= 0;
        end
        else
        begin
            if (result_ch.valid && res_ready)
            begin
                received_cnt <= received_cnt + 1;
                if (escape_counts_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                    begin
                        $display("result beat %0d with nothing pending: iter_count %0d",
                                 received_cnt, result_ch.iter_count);
                    end
                end
                else
                begin
                    want = escape_counts_q.pop_front();
                    if (result_ch.iter_count !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                        begin
                            $display("result beat %0d: iter_count expected %0d, got %0d",
                                     received_cnt, want, result_ch.iter_count);
                        end
                    end
                end
            end
            // one long hold-off so the block backs up its input
            if (!long_done && received_cnt == LONG_HOLD_AT)
            begin
                long_done <= 1'b1;
                long_left <= LONG_HOLD_CYCLES;
                res_ready <= 1'b0;
            end
            else if (long_left != 0)
            begin
                long_left <= long_left - 1;
                res_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                res_ready  <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                begin
                    stall_left <= $urandom_range(1, 15);
                end
            end
        end
    end

    // register write, mirrored into the local copy
    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_JULIA_MODE: live_cfg.julia_mode      = val[0];
            REG_ORIGIN_RE:  live_cfg.origin_re       = val;
            REG_ORIGIN_IM:  live_cfg.origin_im       = val;
            REG_STEP_SIZE:  live_cfg.step_size       = val[STEP_W-1:0];
            REG_ITER_LIMIT: live_cfg.iteration_limit = val[LIMIT_W-1:0];
            REG_CONST_RE:   live_cfg.const_re        = val;
            REG_CONST_IM:   live_cfg.const_im        = val;
            default:        ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_pixel(input logic [INDEX_BITS-1:0] row,
                               input logic [INDEX_BITS-1:0] col);
        pixel_req_t p;
        p.row  = row;
        p.col  = col;
        p.hold = 1'b0;
        pixel_q.push_back(p);
    endtask

    // wait until every queued pixel has come back
    task automatic wait_drained();
        @(negedge clk);
        while (pixel_q.size() != 0 || px_valid || accepted_cnt != received_cnt)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one random phase: new view, then a batch of pixels
    task automatic run_view(input view_t kind, input logic quiet);
        pixel_req_t p;
        int         i;
        case (kind)
            VIEW_MANDEL:
            begin
                write_reg(REG_JULIA_MODE, 32'd0);
                write_reg(REG_ORIGIN_RE, -536870912 + int'($urandom_range(0, 16777216))
                                         - 8388608);
                write_reg(REG_ORIGIN_IM, -402653184);
                write_reg(REG_STEP_SIZE, 196608 >> $urandom_range(0, 2));
                write_reg(REG_ITER_LIMIT, $urandom_range(1, 255));
            end
            VIEW_JULIA:
            begin
                write_reg(REG_JULIA_MODE, 32'd1);
                write_reg(REG_ORIGIN_RE, -429496730);
                write_reg(REG_ORIGIN_IM, -429496730);
                write_reg(REG_STEP_SIZE, 209715);
                write_reg(REG_CONST_RE, int'($urandom_range(0, 536870912)) - 268435456);
                write_reg(REG_CONST_IM, int'($urandom_range(0, 536870912)) - 268435456);
                write_reg(REG_ITER_LIMIT, $urandom_range(16, 255));
            end
            VIEW_WILD:
            begin
                write_reg(REG_JULIA_MODE, $urandom());
                write_reg(REG_ORIGIN_RE, $urandom());
                write_reg(REG_ORIGIN_IM, $urandom());
                write_reg(REG_STEP_SIZE, $urandom());
                write_reg(REG_CONST_RE, $urandom());
                write_reg(REG_CONST_IM, $urandom());
                write_reg(REG_ITER_LIMIT, ($urandom() & 32'hFFFF_0000)
                                          | $urandom_range(0, 40));
            end
            default:
            begin
                // tight window on the set boundary, counts past 255 wrap
                write_reg(REG_JULIA_MODE, 32'd0);
                write_reg(REG_ORIGIN_RE, -201326592 + int'($urandom_range(0, 1048576)));
                write_reg(REG_ORIGIN_IM, 26843546);
                write_reg(REG_STEP_SIZE, $urandom_range(0, 4096));
                write_reg(REG_ITER_LIMIT, $urandom_range(256, 300));
            end
        endcase
        end_writes();
        calm = quiet;
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            p.row  = pick_index();
            p.col  = pick_index();
            p.hold = !quiet && (i == PHASE_ITEMS / 2 || $urandom_range(0, 59) == 0);
            pixel_q.push_back(p);
        end
        wait_drained();
    endtask

    // stimulus sequence
    initial
    begin
        live_cfg.julia_mode      = RST_JULIA_MODE;
        live_cfg.origin_re       = RST_ORIGIN_RE;
        live_cfg.origin_im       = RST_ORIGIN_IM;
        live_cfg.step_size       = RST_STEP_SIZE;
        live_cfg.iteration_limit = RST_ITER_LIMIT;
        live_cfg.const_re        = RST_CONST_RE;
        live_cfg.const_im        = RST_CONST_IM;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // settings straight out of reset
        @(negedge clk);
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd0, 12'd4095);
        queue_pixel(12'd4095, 12'd0);
        queue_pixel(12'd1365, 12'd2730);
        wait_drained();

        // zero iteration limit
        write_reg(REG_ITER_LIMIT, 32'd0);
        end_writes();
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        wait_drained();

        // point reaches both word bounds, saturating at the top, step written with its unused top bit set
        write_reg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_IM, 32'h8000_0000);
        write_reg(REG_STEP_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_ITER_LIMIT, 32'd5);
        end_writes();
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd4095, 12'd0);
        wait_drained();

        // julia update saturates against extreme constants
        write_reg(REG_JULIA_MODE, 32'd1);
        write_reg(REG_ORIGIN_RE, 32'd510027366);
        write_reg(REG_ORIGIN_IM, 32'd0);
        write_reg(REG_STEP_SIZE, 32'd0);
        write_reg(REG_CONST_RE, 32'h7FFF_FFFF);
        write_reg(REG_CONST_IM, 32'h8000_0000);
        write_reg(REG_ITER_LIMIT, 32'd8);
        end_writes();
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        wait_drained();

        write_reg(REG_ORIGIN_RE, 32'd0);
        write_reg(REG_CONST_RE, 32'h8000_0000);
        write_reg(REG_CONST_IM, 32'h7FFF_FFFF);
        end_writes();
        queue_pixel(12'd7, 12'd9);
        wait_drained();

        // write to an unused index, then the full limit on a point that never escapes
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(REG_JULIA_MODE, 32'd0);
        write_reg(REG_ORIGIN_IM, 32'd0);
        write_reg(REG_ITER_LIMIT, 32'hFFFF_FFFF);
        end_writes();
        queue_pixel(12'd4095, 12'd0);
        wait_drained();

        // count wraps modulo 256
        write_reg(REG_ITER_LIMIT, 32'd256);
        end_writes();
        queue_pixel(12'd0, 12'd0);
        wait_drained();
        write_reg(REG_ITER_LIMIT, 32'd257);
        end_writes();
        queue_pixel(12'd0, 12'd4095);
        wait_drained();

        // random views, the last one without idling
        run_view(VIEW_MANDEL, 1'b0);
        run_view(VIEW_JULIA, 1'b0);
        run_view(VIEW_WILD, 1'b0);
        run_view(VIEW_WRAP, 1'b0);
        run_view(VIEW_MANDEL, 1'b0);
        run_view(VIEW_JULIA, 1'b1);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_cnt == 0 && escape_counts_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/etf_pkg.sv
sv/etf_in_if.sv
sv/etf_out_if.sv
sv/etf_cfg_regs.sv
sv/etf_datapath.sv
sv/etf_ctrl.sv
sv/escape_time_fractal_iterator_top.sv
bench/testbench.sv
